// ===== hw/rtl/mava_pkg.sv =====
// mava_pkg: shared types and fixed constants for the mesh area/volume accumulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mava_pkg;

  localparam int FIELD_W  = 12;  // width of one coordinate field on the ports
  localparam int FIELD_XW = 13;  // field zero-extended to the widest coordinate
  localparam int AREA_W   = 48;
  localparam int VOL_W    = 56;

  // status of the decoupling queue as seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mava_fifo.sv =====
// mava_fifo: small register queue between front and back.
// Depends on mava_pkg (fifo_status_t). DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module mava_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   rd,
  output logic [WIDTH-1:0]       rdata,
  output mava_pkg::fifo_status_t status
);
  import mava_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mava_front.sv =====
// mava_front: accepts a triangle and forms |n|^2 and the 6x volume term with one
// shared multiplier stepped by a sequencer. Depends on mava_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mava_front #(
  parameter int C  = 12,
  parameter int N  = 2 * C + 3,
  parameter int VW = 3 * C + 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [8:0][C-1:0]      crd_in,
  input  logic                   last_in,
  input  mava_pkg::fifo_status_t q_st,
  output logic                   q_push,
  output logic [2*N-1:0]         q_norm,
  output logic signed [VW-1:0]   q_vol,
  output logic                   q_last
);
  import mava_pkg::*;

  localparam int D  = C + 1;      // edge component
  localparam int W  = 2 * C + 1;  // one component of b x c
  localparam int PW = 2 * N;

  localparam logic [4:0] ST_NX0 = 5'd0,  ST_NX1 = 5'd1,  ST_NY0 = 5'd2,  ST_NY1 = 5'd3;
  localparam logic [4:0] ST_NZ0 = 5'd4,  ST_NZ1 = 5'd5,  ST_SQX = 5'd6,  ST_SQY = 5'd7;
  localparam logic [4:0] ST_SQZ = 5'd8,  ST_WX0 = 5'd9,  ST_WX1 = 5'd10, ST_VX  = 5'd11;
  localparam logic [4:0] ST_WY0 = 5'd12, ST_WY1 = 5'd13, ST_VY  = 5'd14, ST_WZ0 = 5'd15;
  localparam logic [4:0] ST_WZ1 = 5'd16, ST_VZ  = 5'd17, ST_HAND = 5'd18;

  logic signed [C-1:0] crd [9];
  logic signed [D-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [N-1:0] nx, ny, nz;
  logic signed [W-1:0] w;
  logic [4:0]          step;
  logic                busy;
  logic signed [N-1:0]  opa, opb;
  logic signed [PW-1:0] prod;
  logic                 accept;

  assign full   = busy;
  assign accept = push && !busy;
  assign q_push = busy && (step == ST_HAND) && !q_st.full;

  always_comb begin
    opa = '0;
    opb = '0;
    case (step)
      ST_NX0: begin opa = N'(uy); opb = N'(vz); end
      ST_NX1: begin opa = N'(uz); opb = N'(vy); end
      ST_NY0: begin opa = N'(uz); opb = N'(vx); end
      ST_NY1: begin opa = N'(ux); opb = N'(vz); end
      ST_NZ0: begin opa = N'(ux); opb = N'(vy); end
      ST_NZ1: begin opa = N'(uy); opb = N'(vx); end
      ST_SQX: begin opa = nx; opb = nx; end
      ST_SQY: begin opa = ny; opb = ny; end
      ST_SQZ: begin opa = nz; opb = nz; end
      ST_WX0: begin opa = N'(crd[4]); opb = N'(crd[8]); end
      ST_WX1: begin opa = N'(crd[5]); opb = N'(crd[7]); end
      ST_VX:  begin opa = N'(crd[0]); opb = N'(w); end
      ST_WY0: begin opa = N'(crd[5]); opb = N'(crd[6]); end
      ST_WY1: begin opa = N'(crd[3]); opb = N'(crd[8]); end
      ST_VY:  begin opa = N'(crd[1]); opb = N'(w); end
      ST_WZ0: begin opa = N'(crd[3]); opb = N'(crd[7]); end
      ST_WZ1: begin opa = N'(crd[4]); opb = N'(crd[6]); end
      ST_VZ:  begin opa = N'(crd[2]); opb = N'(w); end
      default: begin opa = '0; opb = '0; end
    endcase
    prod = opa * opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_NX0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= ST_NX0;
    end else if (busy) begin
      if (step == ST_HAND) begin
        if (!q_st.full) busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 9; i++) crd[i] <= $signed(crd_in[i]);
      ux <= D'($signed(crd_in[3])) - D'($signed(crd_in[0]));
      uy <= D'($signed(crd_in[4])) - D'($signed(crd_in[1]));
      uz <= D'($signed(crd_in[5])) - D'($signed(crd_in[2]));
      vx <= D'($signed(crd_in[6])) - D'($signed(crd_in[0]));
      vy <= D'($signed(crd_in[7])) - D'($signed(crd_in[1]));
      vz <= D'($signed(crd_in[8])) - D'($signed(crd_in[2]));
      q_last <= last_in;
    end else if (busy) begin
      case (step)
        ST_NX0: nx <= N'(prod);
        ST_NX1: nx <= nx - N'(prod);
        ST_NY0: ny <= N'(prod);
        ST_NY1: ny <= ny - N'(prod);
        ST_NZ0: nz <= N'(prod);
        ST_NZ1: nz <= nz - N'(prod);
        ST_SQX: q_norm <= PW'(prod);
        ST_SQY: q_norm <= q_norm + PW'(prod);
        ST_SQZ: q_norm <= q_norm + PW'(prod);
        ST_WX0: w <= W'(prod);
        ST_WX1: w <= w - W'(prod);
        ST_VX:  q_vol <= VW'(prod);
        ST_WY0: w <= W'(prod);
        ST_WY1: w <= w - W'(prod);
        ST_VY:  q_vol <= q_vol + VW'(prod);
        ST_WZ0: w <= W'(prod);
        ST_WZ1: w <= w - W'(prod);
        ST_VZ:  q_vol <= q_vol + VW'(prod);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mava_back.sv =====
// mava_back: bit-serial square root, saturating accumulation and the result register.
// Depends on mava_pkg (widths, fifo_status_t).
`timescale 1ns / 1ps
`default_nettype none
module mava_back #(
  parameter int N  = 27,
  parameter int VW = 39
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mava_pkg::fifo_status_t q_st,
  output logic                   q_pop,
  input  logic [2*N-1:0]         q_norm,
  input  logic signed [VW-1:0]   q_vol,
  input  logic                   q_last,
  output logic                   empty,
  input  logic                   pop,
  output logic [mava_pkg::AREA_W-1:0]        area_twice_sum,
  output logic signed [mava_pkg::VOL_W-1:0]  volume_six_sum,
  output logic                   overflowed
);
  import mava_pkg::*;

  localparam int NW = 2 * N;
  localparam int KW = $clog2(N);
  localparam int SW = VOL_W + 1;
  localparam logic signed [SW-1:0] VMAX = SW'((64'd1 << (VOL_W - 1)) - 64'd1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);
  localparam logic [AREA_W-1:0] AMAX = '1;

  localparam logic [1:0] S_IDLE = 2'd0, S_SQRT = 2'd1, S_ACC = 2'd2, S_EMIT = 2'd3;

  logic [1:0]           state;
  logic [KW-1:0]        cnt;
  logic [NW-1:0]        nreg;
  logic [N+1:0]         rem;
  logic [N-1:0]         root;
  logic signed [VW-1:0] vol;
  logic                 last;
  logic [AREA_W-1:0]        aacc;
  logic signed [VOL_W-1:0]  vacc;
  logic                     sat;
  logic                     out_valid;

  logic [N+1:0]        rem_sh, trial;
  logic [AREA_W:0]     asum;
  logic signed [SW-1:0] vsum;
  logic                 emit_go;

  assign empty   = !out_valid;
  assign q_pop   = (state == S_IDLE) && !q_st.empty;
  assign emit_go = (state == S_EMIT) && (!out_valid || pop);

  always_comb begin
    rem_sh = {rem[N-1:0], nreg[NW-1:NW-2]};
    trial  = {root, 2'b01};
    asum   = {1'b0, aacc} + (AREA_W + 1)'(root);
    vsum   = SW'(vacc) + SW'(vol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      aacc      <= '0;
      vacc      <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_st.empty) begin
            state <= S_SQRT;
            cnt   <= '0;
          end
        end
        S_SQRT: begin
          if (cnt == KW'(N - 1)) state <= S_ACC;
          else cnt <= cnt + 1'b1;
        end
        S_ACC: begin
          if (asum[AREA_W]) begin
            aacc <= AMAX;
            sat  <= 1'b1;
          end else begin
            aacc <= asum[AREA_W-1:0];
          end
          if (vsum > VMAX) begin
            vacc <= VMAX[VOL_W-1:0];
            sat  <= 1'b1;
          end else if (vsum < VMIN) begin
            vacc <= VMIN[VOL_W-1:0];
            sat  <= 1'b1;
          end else begin
            vacc <= vsum[VOL_W-1:0];
          end
          state <= last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            aacc      <= '0;
            vacc      <= '0;
            sat       <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: root iteration and result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      nreg <= q_norm;
      vol  <= q_vol;
      last <= q_last;
      rem  <= '0;
      root <= '0;
    end else if (state == S_SQRT) begin
      nreg <= {nreg[NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[N-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[N-2:0], 1'b0};
      end
    end
    if (emit_go) begin
      area_twice_sum <= aacc;
      volume_six_sum <= vacc;
      overflowed     <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mesh_area_volume_accumulator_unit.sv =====
// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+------------------------------------------
// triangle  | in        | push / full        | ax..cz (12b signed), last_triangle
// result    | out       | empty / pop        | area_twice_sum, volume_six_sum, overflowed
//
// Front: one triangle at a time (accept, 18 shared-multiplier steps, handoff); the
// handoff waits while the queue is full. Back: pop, 2*COORD_BITS+3 root steps, add;
//   the back is the slower side and sets the sustained rate; a closing triangle
//   also passes through the emit state.
// Reset (rst, synchronous) empties the queue and clears the sums; the result register
//   keeps its contents until the first mesh closes.
// A waiting result does not stop the back from working; it stalls only when a second
// result is ready before the first is popped, and the front stalls when the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module mesh_area_volume_accumulator_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic signed [mava_pkg::FIELD_W-1:0] ax,
  input  logic signed [mava_pkg::FIELD_W-1:0] ay,
  input  logic signed [mava_pkg::FIELD_W-1:0] az,
  input  logic signed [mava_pkg::FIELD_W-1:0] bx,
  input  logic signed [mava_pkg::FIELD_W-1:0] by_coord,
  input  logic signed [mava_pkg::FIELD_W-1:0] bz,
  input  logic signed [mava_pkg::FIELD_W-1:0] cx,
  input  logic signed [mava_pkg::FIELD_W-1:0] cy,
  input  logic signed [mava_pkg::FIELD_W-1:0] cz,
  input  logic last_triangle,
  output logic empty,
  input  logic pop,
  output logic [mava_pkg::AREA_W-1:0]       area_twice_sum,
  output logic signed [mava_pkg::VOL_W-1:0] volume_six_sum,
  output logic overflowed
);
  import mava_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int N  = 2 * C + 3;   // cross-product component, signed
  localparam int VW = 3 * C + 3;   // 6x volume term, signed
  localparam int QW = 2 * N + VW + 1;

  logic [FIELD_W-1:0]  raw [9];
  logic [8:0][C-1:0]   crd;

  assign raw[0] = ax;
  assign raw[1] = ay;
  assign raw[2] = az;
  assign raw[3] = bx;
  assign raw[4] = by_coord;
  assign raw[5] = bz;
  assign raw[6] = cx;
  assign raw[7] = cy;
  assign raw[8] = cz;

  // each coordinate is the low COORD_BITS of its field, upper field bits ignored
  for (genvar i = 0; i < 9; i++) begin : g_trim
    logic [FIELD_XW-1:0] z;
    assign z      = {1'b0, raw[i]};
    assign crd[i] = z[C-1:0];
  end

  fifo_status_t         q_st;
  logic                 q_push, q_pop;
  logic [2*N-1:0]       f_norm, b_norm;
  logic signed [VW-1:0] f_vol, b_vol;
  logic                 f_last, b_last;
  logic [QW-1:0]        q_rdata;

  mava_front #(.C(C), .N(N), .VW(VW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .crd_in(crd), .last_in(last_triangle), .q_st(q_st),
    .q_push(q_push), .q_norm(f_norm), .q_vol(f_vol), .q_last(f_last)
  );

  mava_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wdata({f_norm, f_vol, f_last}),
    .rd(q_pop), .rdata(q_rdata), .status(q_st)
  );

  assign b_norm = q_rdata[QW-1 -: 2*N];
  assign b_vol  = $signed(q_rdata[VW:1]);
  assign b_last = q_rdata[0];

  mava_back #(.N(N), .VW(VW)) u_back (
    .clk(clk), .rst(rst), .q_st(q_st), .q_pop(q_pop),
    .q_norm(b_norm), .q_vol(b_vol), .q_last(b_last),
    .empty(empty), .pop(pop),
    .area_twice_sum(area_twice_sum), .volume_six_sum(volume_six_sum),
    .overflowed(overflowed)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/mava_checker.sv =====
// mava_checker: port-level assertions for mesh_area_volume_accumulator_unit.
// Depends on mava_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none
module mava_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic pop,
  input logic empty,
  input logic [mava_pkg::AREA_W-1:0] area_twice_sum,
  input logic [mava_pkg::VOL_W-1:0]  volume_six_sum,
  input logic overflowed
);
  import mava_pkg::*;

  // reset leaves both sides idle
  a_reset: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("not idle after reset");

  // the front works through its steps after an accept, so an accept always fills it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("front ready right after accept");

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(area_twice_sum) &&
      $stable(volume_six_sum) && $stable(overflowed))
    else $error("result changed while waiting");

endmodule

bind mesh_area_volume_accumulator_unit mava_checker u_mava_checker (.*);
`default_nettype wire

// ===== dv/tb_mesh_area_volume_accumulator_unit.sv =====
// Self-checking testbench for mesh_area_volume_accumulator_unit: triangles in, per-mesh sums out.
// Depends on mava_pkg and the unit RTL only; no files, no arguments.
`timescale 1ns / 1ps
`default_nettype none
module tb_mesh_area_volume_accumulator_unit;
  import mava_pkg::*;

  // one triangle word: coordinates in order ax, ay, az, bx, by, bz, cx, cy, cz
  typedef struct {
    logic [8:0][FIELD_W-1:0] crd;
    logic                    last;
  } tri_word_t;

  // sums expected when a mesh closes
  typedef struct {
    logic [AREA_W-1:0] area;
    logic [VOL_W-1:0]  vol;
    logic              ovf;
  } mesh_sums_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, overflowed;
  logic signed [FIELD_W-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
  logic signed [FIELD_W-1:0] cx = '0, cy = '0, cz = '0;
  logic last_triangle = 1'b0;
  logic [AREA_W-1:0]       area_twice_sum;
  logic signed [VOL_W-1:0] volume_six_sum;

  mesh_area_volume_accumulator_unit u_dut (
    .clk, .rst, .push, .full, .ax, .ay, .az, .bx, .by_coord, .bz, .cx, .cy, .cz,
    .last_triangle, .empty, .pop, .area_twice_sum, .volume_six_sum, .overflowed
  );

  initial begin
    forever #4 clk = ~clk;
  end

  tri_word_t  tri_q[$];        // triangles waiting to be offered
  mesh_sums_t mesh_sums_q[$];  // sums owed by the block, oldest first
  int         mismatches = 0;
  int         meshes_seen = 0;
  bit         held_off = 1'b0;

  // running copy of the accumulator state
  logic [AREA_W-1:0] acc_area = '0;
  longint            acc_vol = 0;
  logic              acc_sat = 1'b0;

  localparam longint unsigned AREA_TOP = (64'd1 << AREA_W) - 1;
  localparam longint          VOL_TOP  = (64'sd1 <<< (VOL_W - 1)) - 1;
  localparam longint          VOL_BOT  = -VOL_TOP - 1;

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
  endtask

  // floor square root, two bits per step
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // fold one accepted triangle into the sums; queue the result on the closing one
  task automatic accumulate_triangle(tri_word_t w);
    longint p[9];
    longint ux, uy, uz, vx, vy, vz, nx, ny, nz, vol6, vsum;
    longint unsigned norm2, asum;
    mesh_sums_t s;
    for (int i = 0; i < 9; i++) p[i] = $signed(w.crd[i]);
    ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
    vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    norm2 = nx * nx + ny * ny + nz * nz;
    vol6 = p[0] * (p[4] * p[8] - p[5] * p[7]) + p[1] * (p[5] * p[6] - p[3] * p[8])
         + p[2] * (p[3] * p[7] - p[4] * p[6]);
    asum = longint'(acc_area) + floor_root(norm2);
    if (asum > AREA_TOP) begin
      asum = AREA_TOP;
      acc_sat = 1'b1;
    end
    acc_area = asum[AREA_W-1:0];
    vsum = acc_vol + vol6;
    if (vsum > VOL_TOP) begin
      vsum = VOL_TOP;
      acc_sat = 1'b1;
    end else if (vsum < VOL_BOT) begin
      vsum = VOL_BOT;
      acc_sat = 1'b1;
    end
    acc_vol = vsum;
    if (w.last) begin
      s.area = acc_area;
      s.vol  = acc_vol[VOL_W-1:0];
      s.ovf  = acc_sat;
      mesh_sums_q.push_back(s);
      acc_area = '0;
      acc_vol  = 0;
      acc_sat  = 1'b0;
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --- driver: offers queued triangles, keeps push up until accepted ---
  int        send_gap = 0;
  int        send_burst = 0;
  tri_word_t cur;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) accumulate_triangle(cur);
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (tri_q.size() > 0) begin
          cur = tri_q.pop_front();
          {cz, cy, cx, bz, by_coord, bx, az, ay, ax} <= cur.crd;
          last_triangle <= cur.last;
          push <= 1'b1;
          if (send_burst > 0) send_burst--;
          else if ($urandom_range(0, 63) == 0) send_burst = $urandom_range(20, 80);
          send_gap = (send_burst > 0) ? 0 : idle_cycles();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --- monitor: pops results, checks each field against the oldest sums ---
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        meshes_seen++;
        if (mesh_sums_q.size() == 0) begin
          report_mismatch("unexpected word", area_twice_sum, 0);
        end else begin
          mesh_sums_t e;
          e = mesh_sums_q.pop_front();
          if (area_twice_sum !== e.area) report_mismatch("area_twice_sum", area_twice_sum, e.area);
          if (volume_six_sum !== e.vol) report_mismatch("volume_six_sum", volume_six_sum, e.vol);
          if (overflowed !== e.ovf) report_mismatch("overflowed", overflowed, e.ovf);
        end
        // one long hold-off so the block backs up and stalls its input
        if (meshes_seen == 20 && !held_off) begin
          held_off = 1'b1;
          recv_gap = 3000;
        end else begin
          recv_gap = idle_cycles();
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic logic [FIELD_W-1:0] rand_coord(int span);
    return FIELD_W'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_tri(logic [8:0][FIELD_W-1:0] c, logic last);
    tri_word_t w;
    w.crd  = c;
    w.last = last;
    tri_q.push_back(w);
  endtask

  // --- stimulus ---
  initial begin
    logic [8:0][FIELD_W-1:0] c;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    int span, mesh_len;
    lo = {1'b1, {(FIELD_W-1){1'b0}}};
    hi = {1'b0, {(FIELD_W-1){1'b1}}};

    // directed: extremes, degenerate shapes, single and multi triangle meshes
    add_tri({9{12'd0}}, 1'b1);                            // all-zero triangle
    add_tri({9{lo}}, 1'b1);                               // all at the low corner
    add_tri({9{hi}}, 1'b1);                               // all at the high corner
    add_tri({hi, lo, lo, lo, hi, lo, lo, lo, hi}, 1'b0);  // large negative volume
    add_tri({lo, hi, hi, hi, lo, hi, hi, hi, lo}, 1'b0);
    add_tri({lo, lo, hi, lo, hi, lo, hi, lo, lo}, 1'b1);  // positive volume
    add_tri({hi, hi, lo, lo, hi, hi, hi, lo, hi}, 1'b1);
    add_tri({12'd3, 12'd3, 12'd3, 12'd2, 12'd2, 12'd2, 12'd1, 12'd1, 12'd1}, 1'b1); // collinear
    add_tri({12'd5, 12'd6, 12'd7, 12'd5, 12'd6, 12'd7, 12'd1, 12'd2, 12'd3}, 1'b1); // repeated vertex
    add_tri({12'd0, 12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'd1, 12'd0, 12'd0}, 1'b0); // unit triangle
    add_tri({12'd1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 12'd1, 12'd0}, 1'b0);
    add_tri({lo, 12'd0, 12'd0, 12'd0, lo, 12'd0, 12'd0, 12'd0, lo}, 1'b1);
    add_tri({hi, lo, hi, lo, hi, lo, hi, lo, hi}, 1'b1);

    // random meshes: mostly full-range coordinates, some small local patches
    while (tri_q.size() < 1700) begin
      mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 2048;
      for (int t = 0; t < mesh_len; t++) begin
        for (int i = 0; i < 9; i++)
          c[i] = (span == 2048) ? FIELD_W'($urandom) : rand_coord(span);
        if ($urandom_range(0, 15) == 0) c[8:6] = c[2:0];  // degenerate: third on first
        add_tri(c, t == mesh_len - 1);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: all words offered and every mesh checked
    while (tri_q.size() > 0 || push || mesh_sums_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("PASS mesh_area_volume_accumulator_unit");
    else $display("FAIL mesh_area_volume_accumulator_unit");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL mesh_area_volume_accumulator_unit");
    $finish;
  end

endmodule
`default_nettype wire
